@@ rtl/pttc_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pttc_pkg
// Shared types and constants of the pan/tilt tracking controller.
// ----------------------------------------------------------------------------
package pttc_pkg;

  typedef enum logic [1:0] {
    CMD_COORD = 2'd0,
    CMD_TICK  = 2'd1,
    CMD_JOG   = 2'd2,
    CMD_SET   = 2'd3
  } pttc_cmd_e;

  typedef enum logic [1:0] {
    REG_LOW_LIMIT  = 2'd0,
    REG_HIGH_LIMIT = 2'd1,
    REG_JOG_COUNT  = 2'd2,
    REG_UNUSED     = 2'd3
  } pttc_reg_e;

  typedef struct packed {
    logic coord;
    logic tick;
    logic jog;
  } pttc_step_ctrl_t;

  localparam int unsigned ServoW = 16;
  localparam int unsigned StepW  = 8;
  localparam int unsigned MagW   = 16;

  localparam logic [ServoW-1:0] SERVO_RESET = 16'd12000;
  localparam logic [ServoW-1:0] LOW_RESET   = 16'd9000;
  localparam logic [ServoW-1:0] HIGH_RESET  = 16'd15000;
  localparam logic [StepW-1:0]  JOG_RESET   = 8'd100;

  // vertical tiers
  localparam logic [MagW-1:0] V_THR_200 = 16'd200;
  localparam logic [MagW-1:0] V_THR_150 = 16'd150;
  localparam logic [MagW-1:0] V_THR_100 = 16'd100;
  localparam logic [MagW-1:0] V_THR_50  = 16'd50;
  localparam logic [7:0] V_INC_200 = 8'd200;
  localparam logic [7:0] V_INC_100 = 8'd100;
  localparam logic [7:0] V_INC_50  = 8'd50;
  localparam logic [7:0] V_INC_25  = 8'd25;
  localparam logic [7:0] V_INC_10  = 8'd10;

  // horizontal tiers
  localparam logic [MagW-1:0] H_THR_400 = 16'd400;
  localparam logic [MagW-1:0] H_THR_300 = 16'd300;
  localparam logic [MagW-1:0] H_THR_200 = 16'd200;
  localparam logic [MagW-1:0] H_THR_100 = 16'd100;
  localparam logic [StepW-1:0] H_STEPS_40 = 8'd40;
  localparam logic [StepW-1:0] H_STEPS_30 = 8'd30;
  localparam logic [StepW-1:0] H_STEPS_20 = 8'd20;
  localparam logic [StepW-1:0] H_STEPS_15 = 8'd15;
  localparam logic [StepW-1:0] H_STEPS_10 = 8'd10;

endpackage
`default_nettype wire

@@ rtl/pttc_servo.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pttc_servo
// Tiered servo increment from the vertical error, signed add and clamp.
// ----------------------------------------------------------------------------
module pttc_servo #(
  parameter int unsigned CoordBits = 12
) (
  input  wire logic [CoordBits-1:0]       target_y_i,
  input  wire logic [CoordBits-1:0]       ref_y_i,
  input  wire logic [pttc_pkg::ServoW-1:0] servo_i,
  input  wire logic [pttc_pkg::ServoW-1:0] low_limit_i,
  input  wire logic [pttc_pkg::ServoW-1:0] high_limit_i,
  output logic      [pttc_pkg::ServoW-1:0] servo_next_o
);
  import pttc_pkg::*;

  localparam int unsigned SumW = ServoW + 2;

  logic [CoordBits:0]   diff;
  logic [CoordBits:0]   diff_neg;
  logic [CoordBits-1:0] mag;
  logic [MagW-1:0]      mag_ext;
  logic [7:0]           inc;
  logic [SumW-1:0]      inc_ext;
  logic [SumW-1:0]      sum;
  logic [SumW-1:0]      low_ext;
  logic [SumW-1:0]      high_ext;
  logic [SumW-1:0]      clamp_lo;
  logic                 dy_pos;

  always_comb begin
    diff     = {1'b0, target_y_i} - {1'b0, ref_y_i};
    diff_neg = -diff;
    mag      = diff[CoordBits] ? diff_neg[CoordBits-1:0] : diff[CoordBits-1:0];
    mag_ext  = MagW'(mag);
    dy_pos   = !diff[CoordBits] && (diff != '0);

    if (mag_ext > V_THR_200) begin
      inc = V_INC_200;
    end else if (mag_ext > V_THR_150) begin
      inc = V_INC_100;
    end else if (mag_ext > V_THR_100) begin
      inc = V_INC_50;
    end else if (mag_ext > V_THR_50) begin
      inc = V_INC_25;
    end else begin
      inc = V_INC_10;
    end

    inc_ext  = dy_pos ? -SumW'(inc) : SumW'(inc);
    sum      = SumW'(servo_i) + inc_ext;
    low_ext  = SumW'(low_limit_i);
    high_ext = SumW'(high_limit_i);

    clamp_lo = ($signed(sum) < $signed(low_ext)) ? low_ext : sum;
    if ($signed(clamp_lo) > $signed(high_ext)) begin
      servo_next_o = high_limit_i;
    end else begin
      servo_next_o = clamp_lo[ServoW-1:0];
    end
  end

endmodule
`default_nettype wire

@@ rtl/pttc_stepper.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pttc_stepper
// Step count, step pin and direction state; tiered load from horizontal error, jog load.
// ----------------------------------------------------------------------------
module pttc_stepper #(
  parameter int unsigned CoordBits = 12
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire pttc_pkg::pttc_step_ctrl_t  ctrl_i,
  input  wire logic [CoordBits-1:0]       target_x_i,
  input  wire logic [CoordBits-1:0]       ref_x_i,
  input  wire logic [pttc_pkg::StepW-1:0] jog_count_i,
  output logic                            step_pin_o,
  output logic                            step_dir_o,
  output logic      [pttc_pkg::StepW-1:0] steps_left_o
);
  import pttc_pkg::*;

  logic [CoordBits:0]   diff;
  logic [CoordBits:0]   diff_neg;
  logic [CoordBits-1:0] mag;
  logic [MagW-1:0]      mag_ext;
  logic [StepW-1:0]     tier_steps;

  logic [StepW-1:0] count_d, count_q;
  logic             level_d, level_q;
  logic             dir_d, dir_q;

  always_comb begin
    diff     = {1'b0, target_x_i} - {1'b0, ref_x_i};
    diff_neg = -diff;
    mag      = diff[CoordBits] ? diff_neg[CoordBits-1:0] : diff[CoordBits-1:0];
    mag_ext  = MagW'(mag);

    if (mag_ext > H_THR_400) begin
      tier_steps = H_STEPS_40;
    end else if (mag_ext > H_THR_300) begin
      tier_steps = H_STEPS_30;
    end else if (mag_ext > H_THR_200) begin
      tier_steps = H_STEPS_20;
    end else if (mag_ext > H_THR_100) begin
      tier_steps = H_STEPS_15;
    end else begin
      tier_steps = H_STEPS_10;
    end

    count_d = count_q;
    level_d = level_q;
    dir_d   = dir_q;
    if (ctrl_i.coord) begin
      count_d = tier_steps;
      dir_d   = !diff[CoordBits];
    end else if (ctrl_i.tick) begin
      if (count_q != '0) begin
        if (level_q) begin
          level_d = 1'b0;
          count_d = count_q - StepW'(1);
        end else begin
          level_d = 1'b1;
        end
      end else begin
        level_d = 1'b0;
      end
    end else if (ctrl_i.jog) begin
      count_d = jog_count_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      level_q <= 1'b0;
      dir_q   <= 1'b0;
    end else begin
      count_q <= count_d;
      level_q <= level_d;
      dir_q   <= dir_d;
    end
  end

  assign step_pin_o   = level_q;
  assign step_dir_o   = dir_q;
  assign steps_left_o = count_q;

endmodule
`default_nettype wire

@@ rtl/pan_tilt_tracking_controller.sv @@
// Result path: input register, then state/result register; out_valid_o is set
// together with the state update of the item.
// Throughput: one item per cycle while out_ready_i does not stall the output;
// the state update of one item is ready for the next item in the following cycle.
// Reset (rst_ni low, async): servo 12000, step count/pin/direction 0,
// limits 9000/15000, jog count 100, pipeline empty.
`default_nettype none
// ----------------------------------------------------------------------------
// pan_tilt_tracking_controller
// Servo tilt tracking and stepper pan stepping from spot coordinates.
// ----------------------------------------------------------------------------
module pan_tilt_tracking_controller #(
  parameter int unsigned COORD_BITS = 12
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire logic [1:0]            command_i,
  input  wire logic [COORD_BITS-1:0] ref_x_i,
  input  wire logic [COORD_BITS-1:0] ref_y_i,
  input  wire logic [COORD_BITS-1:0] target_x_i,
  input  wire logic [COORD_BITS-1:0] target_y_i,
  input  wire logic [15:0]           servo_value_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic [15:0]                servo_position_o,
  output logic                       step_pin_o,
  output logic                       step_direction_o,
  output logic [7:0]                 steps_left_o,
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [1:0]            cfg_index_i,
  input  wire logic [15:0]           cfg_data_i
);
  import pttc_pkg::*;

  logic                  in_valid_q;
  pttc_cmd_e             cmd_q;
  logic [COORD_BITS-1:0] ref_x_q, ref_y_q, target_x_q, target_y_q;
  logic [ServoW-1:0]     servo_value_q;
  logic                  out_valid_q;
  logic                  advance;

  logic [ServoW-1:0] low_q, high_q;
  logic [StepW-1:0]  jog_q;
  logic [ServoW-1:0] servo_q, servo_d, servo_track;
  pttc_step_ctrl_t   step_ctrl;
  pttc_reg_e         cfg_reg;

  assign advance     = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !in_valid_q || advance;
  assign cfg_ready_o = 1'b1;
  assign cfg_reg     = pttc_reg_e'(cfg_index_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      cmd_q         <= pttc_cmd_e'(command_i);
      ref_x_q       <= ref_x_i;
      ref_y_q       <= ref_y_i;
      target_x_q    <= target_x_i;
      target_y_q    <= target_y_i;
      servo_value_q <= servo_value_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_q  <= LOW_RESET;
      high_q <= HIGH_RESET;
      jog_q  <= JOG_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_reg)
        REG_LOW_LIMIT:  low_q  <= cfg_data_i;
        REG_HIGH_LIMIT: high_q <= cfg_data_i;
        REG_JOG_COUNT:  jog_q  <= cfg_data_i[StepW-1:0];
        default: ;
      endcase
    end
  end

  pttc_servo #(
    .CoordBits(COORD_BITS)
  ) u_servo (
    .target_y_i  (target_y_q),
    .ref_y_i     (ref_y_q),
    .servo_i     (servo_q),
    .low_limit_i (low_q),
    .high_limit_i(high_q),
    .servo_next_o(servo_track)
  );

  always_comb begin
    step_ctrl = '0;
    servo_d   = servo_q;
    if (advance) begin
      case (cmd_q)
        CMD_COORD: begin
          step_ctrl.coord = 1'b1;
          servo_d         = servo_track;
        end
        CMD_TICK: step_ctrl.tick = 1'b1;
        CMD_JOG:  step_ctrl.jog  = 1'b1;
        CMD_SET:  servo_d        = servo_value_q;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      servo_q <= SERVO_RESET;
    end else begin
      servo_q <= servo_d;
    end
  end

  pttc_stepper #(
    .CoordBits(COORD_BITS)
  ) u_stepper (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (step_ctrl),
    .target_x_i  (target_x_q),
    .ref_x_i     (ref_x_q),
    .jog_count_i (jog_q),
    .step_pin_o  (step_pin_o),
    .step_dir_o  (step_direction_o),
    .steps_left_o(steps_left_o)
  );

  assign out_valid_o      = out_valid_q;
  assign servo_position_o = servo_q;

endmodule
`default_nettype wire

@@ tb/sv/pan_tilt_tracking_controller_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pan_tilt_tracking_controller_tb
// Self-checking bench for the pan/tilt tracking controller. A short directed
// sequence covers the tier boundaries, the coordinate extremes, ticks with and
// without steps, jog and direct set. Eight randomized phases follow, each
// with its own limit/jog register setting and one of four idle/stall patterns.
// A scoreboard predicts the state after every input transfer and compares it,
// field by field, with each result transfer.
// ----------------------------------------------------------------------------
module pan_tilt_tracking_controller_tb;
  import pttc_pkg::*;

  localparam int unsigned ItemsPerPhase = 229;

  typedef struct packed {
    logic [15:0] servo;
    logic        pin;
    logic        dir;
    logic [7:0]  steps;
  } track_state_t;

  class tracking_scoreboard;
    logic [15:0]  low_limit;
    logic [15:0]  high_limit;
    logic [7:0]   jog_count;
    track_state_t now;
    track_state_t expected_q[$];
    int unsigned  errors;
    int unsigned  checked;
    int unsigned  cmd_seen[4];

    function new();
      low_limit  = LOW_RESET;
      high_limit = HIGH_RESET;
      jog_count  = JOG_RESET;
      now.servo  = SERVO_RESET;
      now.pin    = 1'b0;
      now.dir    = 1'b0;
      now.steps  = '0;
      errors     = 0;
      checked    = 0;
      foreach (cmd_seen[i]) cmd_seen[i] = 0;
    endfunction

    function void write_reg(pttc_reg_e idx, logic [15:0] data);
      case (idx)
        REG_LOW_LIMIT:  low_limit = data;
        REG_HIGH_LIMIT: high_limit = data;
        REG_JOG_COUNT:  jog_count = data[7:0];
        default: ;
      endcase
    endfunction

    function void note_input(pttc_cmd_e c, logic [11:0] rx, logic [11:0] ry,
                             logic [11:0] tx, logic [11:0] ty, logic [15:0] sv);
      int dx;
      int dy;
      int mag;
      int inc;
      int sum;
      cmd_seen[c]++;
      case (c)
        CMD_COORD: begin
          dx  = int'({20'd0, tx}) - int'({20'd0, rx});
          dy  = int'({20'd0, ty}) - int'({20'd0, ry});
          mag = dy < 0 ? -dy : dy;
          if (mag > 200) inc = 200;
          else if (mag > 150) inc = 100;
          else if (mag > 100) inc = 50;
          else if (mag > 50) inc = 25;
          else inc = 10;
          if (dy > 0) inc = -inc;
          sum = int'({16'd0, now.servo}) + inc;
          // low clamp first, so crossed limits end on the high limit
          if (sum < int'({16'd0, low_limit})) sum = int'({16'd0, low_limit});
          if (sum > int'({16'd0, high_limit})) sum = int'({16'd0, high_limit});
          now.servo = sum[15:0];
          mag = dx < 0 ? -dx : dx;
          if (mag > 400) now.steps = 8'd40;
          else if (mag > 300) now.steps = 8'd30;
          else if (mag > 200) now.steps = 8'd20;
          else if (mag > 100) now.steps = 8'd15;
          else now.steps = 8'd10;
          now.dir = dx < 0 ? 1'b0 : 1'b1;
        end
        CMD_TICK: begin
          if (now.steps != 0) begin
            if (now.pin) begin
              now.pin   = 1'b0;
              now.steps = now.steps - 8'd1;
            end else begin
              now.pin = 1'b1;
            end
          end else begin
            now.pin = 1'b0;
          end
        end
        CMD_JOG: now.steps = jog_count;
        default: now.servo = sv;
      endcase
      expected_q.push_back(now);
    endfunction

    function void mismatch(string field, logic [15:0] want, logic [15:0] got);
      errors++;
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    endfunction

    function void check_result(track_state_t got);
      track_state_t want;
      checked++;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t ns: unexpected result, expected none, actual servo %0d steps %0d",
                 $time, got.servo, got.steps);
        return;
      end
      want = expected_q.pop_front();
      if (got.servo !== want.servo) mismatch("servo_position", want.servo, got.servo);
      if (got.pin !== want.pin) mismatch("step_pin", want.pin, got.pin);
      if (got.dir !== want.dir) mismatch("step_direction", want.dir, got.dir);
      if (got.steps !== want.steps) mismatch("steps_left", want.steps, got.steps);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  pttc_cmd_e   cmd;
  logic [11:0] ref_x;
  logic [11:0] ref_y;
  logic [11:0] target_x;
  logic [11:0] target_y;
  logic [15:0] servo_value;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] servo_pos;
  logic        step_pin;
  logic        step_dir;
  logic [7:0]  steps_left;
  logic        cfg_valid;
  logic        cfg_ready;
  pttc_reg_e   cfg_index;
  logic [15:0] cfg_data;

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  tracking_scoreboard sb = new();

  always #6 clk = ~clk;

  pan_tilt_tracking_controller dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .command_i        (cmd),
    .ref_x_i          (ref_x),
    .ref_y_i          (ref_y),
    .target_x_i       (target_x),
    .target_y_i       (target_y),
    .servo_value_i    (servo_value),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .servo_position_o (servo_pos),
    .step_pin_o       (step_pin),
    .step_direction_o (step_dir),
    .steps_left_o     (steps_left),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_o      (cfg_ready),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data)
  );

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      sb.check_result('{servo_pos, step_pin, step_dir, steps_left});
    end
  end

  // called at a falling edge; returns at the falling edge after the transfer
  task automatic send_item(pttc_cmd_e c, logic [11:0] rx, logic [11:0] ry,
                           logic [11:0] tx, logic [11:0] ty, logic [15:0] sv);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    cmd         = c;
    ref_x       = rx;
    ref_y       = ry;
    target_x    = tx;
    target_y    = ty;
    servo_value = sv;
    in_valid    = 1'b1;
    do @(posedge clk); while (!in_ready);
    sb.note_input(c, rx, ry, tx, ty, sv);
    @(negedge clk);
  endtask

  task automatic send_offset(int dx, int dy);
    send_item(CMD_COORD, 12'd2048, 12'd2048, 12'(2048 + dx), 12'(2048 + dy), 16'd0);
  endtask

  task automatic write_cfg(pttc_reg_e idx, logic [15:0] data);
    cfg_index = idx;
    cfg_data  = data;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
    @(negedge clk);
  endtask

  task automatic settle();
    in_valid = 1'b0;
    while (sb.expected_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic apply_setting(int unsigned phase);
    logic [15:0] lo;
    lo = 16'($urandom_range(10000, 13000));
    case (phase)
      0: begin
        write_cfg(REG_LOW_LIMIT, 16'd9000);
        write_cfg(REG_HIGH_LIMIT, 16'd15000);
        write_cfg(REG_JOG_COUNT, 16'd100);
      end
      1: begin
        write_cfg(REG_LOW_LIMIT, 16'd0);
        write_cfg(REG_HIGH_LIMIT, 16'hFFFF);
        write_cfg(REG_JOG_COUNT, 16'd255);
      end
      2: begin
        write_cfg(REG_LOW_LIMIT, 16'd0);
        write_cfg(REG_HIGH_LIMIT, 16'd0);
        write_cfg(REG_JOG_COUNT, 16'hAB00);
      end
      3: begin
        write_cfg(REG_LOW_LIMIT, 16'hFFFF);
        write_cfg(REG_HIGH_LIMIT, 16'hFFFF);
        write_cfg(REG_JOG_COUNT, 16'd1);
        write_cfg(REG_UNUSED, 16'($urandom));
      end
      4: begin
        write_cfg(REG_LOW_LIMIT, 16'd14000);
        write_cfg(REG_HIGH_LIMIT, 16'd10000);
        write_cfg(REG_JOG_COUNT, 16'h1207);
      end
      5: begin
        write_cfg(REG_LOW_LIMIT, lo);
        write_cfg(REG_HIGH_LIMIT, lo + 16'($urandom_range(0, 2000)));
        write_cfg(REG_JOG_COUNT, 16'($urandom_range(1, 60)));
      end
      6: begin
        write_cfg(REG_LOW_LIMIT, 16'hFFFF);
        write_cfg(REG_HIGH_LIMIT, 16'd0);
        write_cfg(REG_JOG_COUNT, 16'($urandom));
      end
      default: begin
        write_cfg(REG_LOW_LIMIT, 16'($urandom));
        write_cfg(REG_HIGH_LIMIT, 16'($urandom));
        write_cfg(REG_JOG_COUNT, 16'($urandom));
      end
    endcase
    cfg_valid = 1'b0;
  endtask

  function automatic logic [11:0] spot_near(logic [11:0] base);
    int d;
    if ($urandom_range(3) == 0) return 12'($urandom_range(4095));
    d = int'($urandom_range(0, 900)) - 450;
    return base + d[11:0];
  endfunction

  function automatic logic [15:0] servo_pick();
    case ($urandom_range(4))
      0: return 16'($urandom);
      1: return {16{1'($urandom_range(1))}};
      2: return sb.low_limit + 16'($urandom_range(0, 400)) - 16'd200;
      default: return sb.high_limit + 16'($urandom_range(0, 400)) - 16'd200;
    endcase
  endfunction

  task automatic send_random();
    int unsigned pick;
    pttc_cmd_e   c;
    logic [11:0] rx;
    logic [11:0] ry;
    pick = $urandom_range(99);
    c  = pick < 35 ? CMD_COORD : pick < 75 ? CMD_TICK : pick < 85 ? CMD_JOG : CMD_SET;
    rx = 12'($urandom_range(4095));
    ry = 12'($urandom_range(4095));
    send_item(c, rx, ry, spot_near(rx), spot_near(ry), servo_pick());
  endtask

  task automatic run_directed();
    send_item(CMD_TICK, 12'd0, 12'd0, 12'd0, 12'd0, 16'd0);
    send_offset(0, 0);
    send_offset(100, 50);
    send_offset(-101, -51);
    send_offset(200, 100);
    send_offset(-201, 101);
    send_offset(300, -150);
    send_offset(301, 151);
    send_offset(-400, 200);
    send_offset(401, -201);
    send_item(CMD_COORD, 12'hFFF, 12'd0, 12'd0, 12'hFFF, 16'hFFFF);
    send_item(CMD_COORD, 12'd0, 12'hFFF, 12'hFFF, 12'd0, 16'd0);
    repeat (3) send_item(CMD_TICK, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 16'hFFFF);
    send_item(CMD_JOG, 12'd0, 12'd0, 12'd0, 12'd0, 16'd0);
    send_item(CMD_TICK, 12'd0, 12'd0, 12'd0, 12'd0, 16'd0);
    send_item(CMD_SET, 12'd0, 12'd0, 12'd0, 12'd0, 16'd0);
    send_offset(0, 1);
    send_item(CMD_SET, 12'd0, 12'd0, 12'd0, 12'd0, 16'hFFFF);
    send_offset(0, -1);
    send_item(CMD_SET, 12'd0, 12'd0, 12'd0, 12'd0, 16'd12000);
  endtask

  initial begin : stimulus
    int unsigned phase;
    in_valid    = 1'b0;
    cmd         = CMD_COORD;
    ref_x       = '0;
    ref_y       = '0;
    target_x    = '0;
    target_y    = '0;
    servo_value = '0;
    cfg_valid   = 1'b0;
    cfg_index   = REG_LOW_LIMIT;
    cfg_data    = '0;
    rst_n       = 1'b0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    run_directed();
    for (phase = 0; phase < 8; phase++) begin
      settle();
      apply_setting(phase);
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 53; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 53; end
        default: begin send_idle_pct = 24; recv_stall_pct = 24; end
      endcase
      repeat (ItemsPerPhase) send_random();
    end
    settle();
    $display("Covered %0d coordinate updates, %0d ticks, %0d jogs, %0d direct sets",
             sb.cmd_seen[CMD_COORD], sb.cmd_seen[CMD_TICK], sb.cmd_seen[CMD_JOG],
             sb.cmd_seen[CMD_SET]);
    $display("over 8 register settings; %0d results checked, %0d mismatches",
             sb.checked, sb.errors);
    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin : watchdog
    #20_000_000;
    $display("Timeout with %0d results outstanding", sb.expected_q.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule
